// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the port-level checker of the gate.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define SDCG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gate check failed");

// Next-cycle implication, ignored while reset is high.
`define SDCG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gate check failed");

// Next-cycle implication that also holds across reset.
`define SDCG_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("gate check failed");

`endif

// ===== rtl/core/sdcg_pkg.sv =====
// Types, codes and helper functions of the source dwell control gate.
package sdcg_pkg;

   localparam int TIME_WIDTH   = 32;
   localparam int FIELD_WIDTH  = 32;
   localparam int CMP_WIDTH    = (TIME_WIDTH > FIELD_WIDTH) ? TIME_WIDTH : FIELD_WIDTH;
   localparam int CSR_IDX_WIDTH = 2;

   typedef logic [TIME_WIDTH-1:0]  time_type;
   typedef logic [FIELD_WIDTH-1:0] field_type;

   typedef enum logic [2:0] {
      MODE_UNKNOWN  = 3'd0,
      MODE_NONE     = 3'd1,
      MODE_GRID     = 3'd2,
      MODE_GEN      = 3'd3,
      MODE_ISLAND   = 3'd4,
      MODE_SYNC     = 3'd5,
      MODE_CONFLICT = 3'd6,
      MODE_TRANSFER = 3'd7
   } mode_type;

   typedef enum logic [2:0] {
      GS_UNCONFIGURED = 3'd0,
      GS_WAITING      = 3'd1,
      GS_STABILIZING  = 3'd2,
      GS_READY        = 3'd3,
      GS_LOST         = 3'd4,
      GS_CONFLICT     = 3'd5
   } gate_state_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_CONFIGURED = 2'd0,
      CSR_DWELL      = 2'd1,
      CSR_LOSS_TRIP  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic      configured;
      field_type recovery_dwell_ms;
      field_type loss_limit_ms;
   } cfg_type;

   typedef struct packed {
      logic      data_current;
      logic      source_allowed;
      mode_type  src_kind;
      field_type stamp_ms;
   } item_type;

   typedef struct packed {
      gate_state_type gate_state;
      logic           ctl_permit;
      logic           dwell_done;
      logic           loss_tripped;
   } result_type;

   // Modes that can carry control.
   function automatic logic mode_carries(input mode_type m);
      logic carries;
      case (m)
         MODE_GRID, MODE_GEN, MODE_ISLAND, MODE_SYNC: carries = 1'b1;
         default:                                     carries = 1'b0;
      endcase
      return carries;
   endfunction

   // True when the wrapping elapsed time reaches limit; a zero limit is immediate.
   function automatic logic elapsed_reaches(input time_type now, input time_type start,
                                            input field_type limit);
      time_type diff;
      diff = now - start;
      return (limit == '0) || (CMP_WIDTH'(diff) >= CMP_WIDTH'(limit));
   endfunction

endpackage

// ===== rtl/core/sdcg_csr.sv =====
// Configuration registers of the gate.
module sdcg_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [sdcg_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [sdcg_pkg::FIELD_WIDTH-1:0]    csr_wdata,
   output sdcg_pkg::cfg_type                   cfg
);

   sdcg_pkg::cfg_type cfg_ff, cfg_in;

   // Decode the write index; unknown indexes drop the write.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (sdcg_pkg::csr_index_type'(csr_index))
            sdcg_pkg::CSR_CONFIGURED: cfg_in.configured        = csr_wdata[0];
            sdcg_pkg::CSR_DWELL:      cfg_in.recovery_dwell_ms = csr_wdata;
            sdcg_pkg::CSR_LOSS_TRIP:  cfg_in.loss_limit_ms     = csr_wdata;
            default:                  cfg_in                   = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/sdcg_core.sv =====
// Dwell and loss tracking state with the per-sample gate decision.
module sdcg_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  sdcg_pkg::cfg_type    cfg,
   input  sdcg_pkg::item_type   item,
   output sdcg_pkg::result_type result
);

   logic               rec_active_ff, rec_active_in;
   sdcg_pkg::mode_type rec_source_ff, rec_source_in;
   sdcg_pkg::time_type rec_start_ff,  rec_start_in;
   logic               loss_active_ff, loss_active_in;
   sdcg_pkg::time_type loss_start_ff,  loss_start_in;

   sdcg_pkg::time_type now;
   logic               carrying;
   logic               conflict;
   logic               absent;
   logic               restart;
   logic               stable;
   logic               lost;

   // Classify the sample.
   assign now      = sdcg_pkg::TIME_WIDTH'(item.stamp_ms);
   assign carrying = item.data_current && item.source_allowed
                     && sdcg_pkg::mode_carries(item.src_kind);
   assign conflict = item.data_current && (item.src_kind == sdcg_pkg::MODE_CONFLICT);
   assign absent   = !item.data_current || (item.src_kind == sdcg_pkg::MODE_UNKNOWN)
                     || (item.src_kind == sdcg_pkg::MODE_NONE);
   assign restart  = !rec_active_ff || (rec_source_ff != item.src_kind);

   // Next state and result for this sample.
   always_comb begin
      rec_active_in  = rec_active_ff;
      rec_source_in  = rec_source_ff;
      rec_start_in   = rec_start_ff;
      loss_active_in = loss_active_ff;
      loss_start_in  = loss_start_ff;
      stable         = 1'b0;
      lost           = 1'b0;
      result         = '0;
      result.gate_state = sdcg_pkg::GS_UNCONFIGURED;

      if (!cfg.configured) begin
         rec_active_in  = 1'b0;
         rec_source_in  = sdcg_pkg::MODE_UNKNOWN;
         rec_start_in   = '0;
         loss_active_in = 1'b0;
         loss_start_in  = '0;
      end else if (carrying) begin
         loss_active_in = 1'b0;
         loss_start_in  = '0;
         if (restart) begin
            rec_active_in = 1'b1;
            rec_source_in = item.src_kind;
            rec_start_in  = now;
         end
         stable = sdcg_pkg::elapsed_reaches(now, rec_start_in, cfg.recovery_dwell_ms);
         result.dwell_done = stable;
         result.ctl_permit = stable;
         result.gate_state = stable ? sdcg_pkg::GS_READY : sdcg_pkg::GS_STABILIZING;
      end else begin
         rec_active_in = 1'b0;
         rec_source_in = sdcg_pkg::MODE_UNKNOWN;
         rec_start_in  = '0;
         if (absent) begin
            if (!loss_active_ff) begin
               loss_active_in = 1'b1;
               loss_start_in  = now;
            end
            lost = sdcg_pkg::elapsed_reaches(now, loss_start_in, cfg.loss_limit_ms);
         end else begin
            loss_active_in = 1'b0;
            loss_start_in  = '0;
         end
         result.loss_tripped = lost;
         if (conflict) begin
            result.gate_state = sdcg_pkg::GS_CONFLICT;
         end else if (absent && lost) begin
            result.gate_state = sdcg_pkg::GS_LOST;
         end else begin
            result.gate_state = sdcg_pkg::GS_WAITING;
         end
      end
   end

   // Advance tracking state once per processed beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         rec_active_ff  <= 1'b0;
         rec_source_ff  <= sdcg_pkg::MODE_UNKNOWN;
         rec_start_ff   <= '0;
         loss_active_ff <= 1'b0;
         loss_start_ff  <= '0;
      end else if (step) begin
         rec_active_ff  <= rec_active_in;
         rec_source_ff  <= rec_source_in;
         rec_start_ff   <= rec_start_in;
         loss_active_ff <= loss_active_in;
         loss_start_ff  <= loss_start_in;
      end
   end

endmodule

// ===== rtl/core/source_dwell_control_gate_top.sv =====
// Top level of the source dwell control gate: input register, decision core, result register.
//
//   channel   ports                         direction  handshake
//   req       req_valid/req_ready + fields  in         valid/ready
//   rsp       rsp_valid/rsp_ready + fields  out        valid/ready
//   csr       csr_we/csr_index/csr_wdata    in         write enable only
//
// A beat is offered on rsp once the result register holds it: it sits in the input
// register while the decision logic runs, and the result register loads on advance.
// One beat per cycle while rsp is not stalled; tracking state advances in the decide cycle.
// Reset clears configuration, tracking state and both valid flags.
// A stalled result holds; the input register still takes a beat while it is empty.
module source_dwell_control_gate_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_data_current,
   input  logic                                req_source_allowed,
   input  logic [2:0]                          req_src_kind,
   input  logic [sdcg_pkg::FIELD_WIDTH-1:0]    req_stamp_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [2:0]                          rsp_gate_state,
   output logic                                rsp_ctl_permit,
   output logic                                rsp_dwell_done,
   output logic                                rsp_loss_tripped,
   input  logic                                csr_we,
   input  logic [sdcg_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [sdcg_pkg::FIELD_WIDTH-1:0]    csr_wdata
);

   sdcg_pkg::cfg_type    cfg;
   sdcg_pkg::item_type   item_ff, item_in;
   sdcg_pkg::result_type result;
   sdcg_pkg::result_type rsp_ff, rsp_in;
   logic                 in_valid_ff, in_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 advance;
   logic                 req_take;

   sdcg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sdcg_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .cfg    (cfg),
      .item   (item_ff),
      .result (result)
   );

   // Move a beat into the result register when that register is free or draining.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      item_in = item_ff;
      if (req_take) begin
         item_in.data_current   = req_data_current;
         item_in.source_allowed = req_source_allowed;
         item_in.src_kind       = sdcg_pkg::mode_type'(req_src_kind);
         item_in.stamp_ms       = req_stamp_ms;
      end
      in_valid_in = req_take || (in_valid_ff && !advance);
   end

   // Load the result on advance, drop it once taken.
   always_comb begin
      rsp_in       = advance ? result : rsp_ff;
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_gate_state   = rsp_ff.gate_state;
   assign rsp_ctl_permit   = rsp_ff.ctl_permit;
   assign rsp_dwell_done   = rsp_ff.dwell_done;
   assign rsp_loss_tripped = rsp_ff.loss_tripped;

endmodule

// ===== rtl/core/sdcg_checker.sv =====
// Port-level checks of the gate, bound to the top level.
`include "assert_macros.svh"

module sdcg_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_gate_state,
   input logic       rsp_ctl_permit,
   input logic       rsp_dwell_done,
   input logic       rsp_loss_tripped
);

   logic ctl_beat;
   logic loss_beat;
   logic ready_clean;
   logic state_lost;
   logic rsp_stall;
   logic flags_agree;

   assign ctl_beat    = rsp_valid && rsp_ctl_permit;
   assign loss_beat   = rsp_valid && rsp_loss_tripped;
   assign ready_clean = (rsp_gate_state == sdcg_pkg::GS_READY) && !rsp_loss_tripped;
   assign state_lost  = (rsp_gate_state == sdcg_pkg::GS_LOST);
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign flags_agree = (rsp_ctl_permit == rsp_dwell_done);

   // Control and dwell completion always agree.
   `SDCG_ASSERT_IMP(a_ctl_matches_stable, clock, reset, rsp_valid, flags_agree)

   // Control only in ready, never with a confirmed loss.
   `SDCG_ASSERT_IMP(a_ctl_only_ready, clock, reset, ctl_beat, ready_clean)

   // A confirmed loss always reports the lost state.
   `SDCG_ASSERT_IMP(a_loss_is_lost, clock, reset, loss_beat, state_lost)

   // A stalled result beat stays offered.
   `SDCG_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_stall, rsp_valid)

   // No result beat right after reset.
   `SDCG_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind source_dwell_control_gate_top sdcg_checker u_sdcg_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_gate_state   (rsp_gate_state),
   .rsp_ctl_permit   (rsp_ctl_permit),
   .rsp_dwell_done   (rsp_dwell_done),
   .rsp_loss_tripped (rsp_loss_tripped)
);

// ===== tb/dwell_gate_checker.sv =====
// Checker for the source dwell control gate: predicts every decision and compares result beats.
module dwell_gate_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic                               req_data_current,
   input  logic                               req_source_allowed,
   input  logic [2:0]                         req_src_kind,
   input  logic [sdcg_pkg::FIELD_WIDTH-1:0]   req_stamp_ms,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [2:0]                         rsp_gate_state,
   input  logic                               rsp_ctl_permit,
   input  logic                               rsp_dwell_done,
   input  logic                               rsp_loss_tripped,
   input  logic                               csr_we,
   input  logic [sdcg_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [sdcg_pkg::FIELD_WIDTH-1:0]   csr_wdata,
   output int                                 mismatches,
   output int                                 outstanding
);

   // shadow configuration
   logic                cfg_on;
   sdcg_pkg::field_type cfg_dwell;
   sdcg_pkg::field_type cfg_trip;

   // shadow tracking state
   logic                dwell_run;
   sdcg_pkg::mode_type  dwell_mode;
   sdcg_pkg::time_type  dwell_t0;
   logic                loss_run;
   sdcg_pkg::time_type  loss_t0;

   sdcg_pkg::result_type verdicts_due[$];
   int                   fail_tally = 0;

   // Clear both timers and the tracked mode.
   function automatic void drop_tracking();
      dwell_run  = 1'b0;
      dwell_mode = sdcg_pkg::MODE_UNKNOWN;
      dwell_t0   = '0;
      loss_run   = 1'b0;
      loss_t0    = '0;
   endfunction

   // Work out the gate decision for one sample and advance the shadow state.
   function automatic sdcg_pkg::result_type gate_decide(input logic fresh,
                                                        input logic allowed,
                                                        input sdcg_pkg::mode_type mode,
                                                        input sdcg_pkg::time_type now);
      sdcg_pkg::result_type verdict;
      sdcg_pkg::time_type   held_ms;
      logic                 carrying;
      logic                 absent;
      verdict  = '0;
      carrying = (mode == sdcg_pkg::MODE_GRID) || (mode == sdcg_pkg::MODE_GEN) ||
                 (mode == sdcg_pkg::MODE_ISLAND) || (mode == sdcg_pkg::MODE_SYNC);
      absent   = !fresh || (mode == sdcg_pkg::MODE_UNKNOWN) || (mode == sdcg_pkg::MODE_NONE);
      if (!cfg_on) begin
         drop_tracking();
      end else if (fresh && allowed && carrying) begin
         loss_run = 1'b0;
         loss_t0  = '0;
         // restart the dwell on a new carrying mode
         if (!dwell_run || dwell_mode != mode) begin
            dwell_run  = 1'b1;
            dwell_mode = mode;
            dwell_t0   = now;
         end
         held_ms = now - dwell_t0;
         verdict.dwell_done = (cfg_dwell == '0) || (held_ms >= cfg_dwell);
         verdict.ctl_permit = verdict.dwell_done;
         verdict.gate_state = verdict.dwell_done ? sdcg_pkg::GS_READY
                                                 : sdcg_pkg::GS_STABILIZING;
      end else begin
         dwell_run  = 1'b0;
         dwell_mode = sdcg_pkg::MODE_UNKNOWN;
         dwell_t0   = '0;
         // stale, unknown or no source runs the loss timer
         if (absent) begin
            if (!loss_run) begin
               loss_run = 1'b1;
               loss_t0  = now;
            end
            held_ms = now - loss_t0;
            verdict.loss_tripped = (cfg_trip == '0) || (held_ms >= cfg_trip);
         end else begin
            loss_run = 1'b0;
            loss_t0  = '0;
         end
         if (fresh && mode == sdcg_pkg::MODE_CONFLICT) begin
            verdict.gate_state = sdcg_pkg::GS_CONFLICT;
         end else if (absent && verdict.loss_tripped) begin
            verdict.gate_state = sdcg_pkg::GS_LOST;
         end else begin
            verdict.gate_state = sdcg_pkg::GS_WAITING;
         end
      end
      return verdict;
   endfunction

   task automatic check_field(input string name, input logic [2:0] want,
                              input logic [2:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_tally++;
      end
   endtask

   always @(posedge clock) begin : watch
      sdcg_pkg::result_type due;
      if (reset) begin
         cfg_on    = 1'b0;
         cfg_dwell = '0;
         cfg_trip  = '0;
         drop_tracking();
         verdicts_due.delete();
      end else begin
         // compare the result beat with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (verdicts_due.size() == 0) begin
               $error("result beat with no prediction waiting: gate_state %0d",
                      rsp_gate_state);
               fail_tally++;
            end else begin
               due = verdicts_due.pop_front();
               check_field("gate_state", due.gate_state, rsp_gate_state);
               check_field("ctl_permit", due.ctl_permit, rsp_ctl_permit);
               check_field("dwell_done", due.dwell_done, rsp_dwell_done);
               check_field("loss_tripped", due.loss_tripped, rsp_loss_tripped);
            end
         end
         // predict each accepted sample beat
         if (req_valid && req_ready) begin
            verdicts_due.push_back(gate_decide(req_data_current, req_source_allowed,
                                               sdcg_pkg::mode_type'(req_src_kind),
                                               sdcg_pkg::time_type'(req_stamp_ms)));
         end
         // track register writes; the spare index is ignored
         if (csr_we) begin
            case (csr_index)
               sdcg_pkg::CSR_CONFIGURED: cfg_on    = csr_wdata[0];
               sdcg_pkg::CSR_DWELL:      cfg_dwell = csr_wdata;
               sdcg_pkg::CSR_LOSS_TRIP:  cfg_trip  = csr_wdata;
               default: ;
            endcase
         end
      end
      mismatches  <= fail_tally;
      outstanding <= verdicts_due.size();
   end

endmodule

// ===== tb/tb_source_dwell_control_gate_top.sv =====
// Testbench top of the source dwell control gate: clock, reset, stimulus and verdict.
module tb_source_dwell_control_gate_top;

   localparam int CYCLE_LIMIT      = 400000;
   localparam int RESET_CYCLES     = 10;
   localparam int RANDOM_PHASES    = 12;
   localparam int PHASE_BEATS      = 127;
   localparam int LONG_HOLD_CYCLES = 150;
   localparam int SETTLE_CYCLES    = 8;
   localparam logic [sdcg_pkg::CSR_IDX_WIDTH-1:0] CSR_SPARE = 2'd3;

   typedef enum logic [1:0] {
      RUN_CARRY,
      RUN_ABSENT,
      RUN_BLOCKED,
      RUN_NOISE
   } run_kind_type;

   logic                               clock              = 1'b0;
   logic                               reset              = 1'b1;
   logic                               req_valid          = 1'b0;
   logic                               req_data_current   = 1'b0;
   logic                               req_source_allowed = 1'b0;
   logic [2:0]                         req_src_kind       = '0;
   logic [sdcg_pkg::FIELD_WIDTH-1:0]   req_stamp_ms       = '0;
   logic                               rsp_ready          = 1'b0;
   logic                               csr_we             = 1'b0;
   logic [sdcg_pkg::CSR_IDX_WIDTH-1:0] csr_index          = '0;
   logic [sdcg_pkg::FIELD_WIDTH-1:0]   csr_wdata          = '0;

   logic       req_ready;
   logic       rsp_valid;
   logic [2:0] rsp_gate_state;
   logic       rsp_ctl_permit;
   logic       rsp_dwell_done;
   logic       rsp_loss_tripped;

   int                  mismatches;
   int                  outstanding;
   int                  cycle_count    = 0;
   logic                gaps_on        = 1'b1;
   logic                long_hold_due  = 1'b0;
   logic                long_hold_done = 1'b0;
   sdcg_pkg::field_type sim_ms         = '0;
   int                  ms_step        = 1;

   always #5 clock = ~clock;

   source_dwell_control_gate_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_current   (req_data_current),
      .req_source_allowed (req_source_allowed),
      .req_src_kind       (req_src_kind),
      .req_stamp_ms       (req_stamp_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_gate_state     (rsp_gate_state),
      .rsp_ctl_permit     (rsp_ctl_permit),
      .rsp_dwell_done     (rsp_dwell_done),
      .rsp_loss_tripped   (rsp_loss_tripped),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   dwell_gate_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_current   (req_data_current),
      .req_source_allowed (req_source_allowed),
      .req_src_kind       (req_src_kind),
      .req_stamp_ms       (req_stamp_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_gate_state     (rsp_gate_state),
      .rsp_ctl_permit     (rsp_ctl_permit),
      .rsp_dwell_done     (rsp_dwell_done),
      .rsp_loss_tripped   (rsp_loss_tripped),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .mismatches         (mismatches),
      .outstanding        (outstanding)
   );

   // Offer one sample beat, after an optional idle burst, and hold it until accepted.
   task automatic send_beat(input logic fresh, input logic allowed,
                            input sdcg_pkg::mode_type mode,
                            input sdcg_pkg::field_type stamp);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data_current   <= fresh;
      req_source_allowed <= allowed;
      req_src_kind       <= mode;
      req_stamp_ms       <= stamp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid and wait until every predicted result has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [sdcg_pkg::CSR_IDX_WIDTH-1:0] index,
                            input sdcg_pkg::field_type value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Reprogram the gate while it is idle; also poke the unused index.
   task automatic apply_config(input logic on, input sdcg_pkg::field_type dwell,
                               input sdcg_pkg::field_type trip);
      sdcg_pkg::field_type word;
      wait_drained();
      word    = $urandom;
      word[0] = on;
      write_reg(CSR_SPARE, $urandom);
      write_reg(sdcg_pkg::CSR_CONFIGURED, word);
      write_reg(sdcg_pkg::CSR_DWELL, dwell);
      write_reg(sdcg_pkg::CSR_LOSS_TRIP, trip);
      csr_we <= 1'b0;
   endtask

   // Drive runs of well-formed evidence with random content, mixed with noise.
   task automatic random_phase(input int beats);
      run_kind_type       kind;
      sdcg_pkg::mode_type carry_mode;
      sdcg_pkg::mode_type mode;
      logic               fresh;
      logic               allowed;
      int                 run_left;
      int                 pick;
      run_left   = 0;
      kind       = RUN_CARRY;
      carry_mode = sdcg_pkg::MODE_GRID;
      for (int n = 0; n < beats; n++) begin
         // pick the next run
         if (run_left == 0) begin
            run_left = $urandom_range(1, 24);
            pick     = $urandom_range(0, 99);
            if (pick < 55) begin
               kind = RUN_CARRY;
            end else if (pick < 80) begin
               kind = RUN_ABSENT;
            end else if (pick < 92) begin
               kind = RUN_BLOCKED;
            end else begin
               kind = RUN_NOISE;
            end
            carry_mode = sdcg_pkg::mode_type'($urandom_range(sdcg_pkg::MODE_GRID,
                                                             sdcg_pkg::MODE_SYNC));
         end
         run_left--;
         // advance the time base; now and then jump anywhere
         if ($urandom_range(0, 39) == 0) begin
            sim_ms = $urandom;
         end else begin
            sim_ms = sim_ms + sdcg_pkg::field_type'($urandom_range(0, ms_step));
         end
         fresh   = 1'b1;
         allowed = 1'b1;
         mode    = carry_mode;
         case (kind)
            RUN_CARRY: begin
               if ($urandom_range(0, 11) == 0) begin
                  carry_mode = sdcg_pkg::mode_type'($urandom_range(sdcg_pkg::MODE_GRID,
                                                                   sdcg_pkg::MODE_SYNC));
                  mode       = carry_mode;
               end
            end
            RUN_ABSENT: begin
               allowed = 1'($urandom_range(0, 1));
               case ($urandom_range(0, 2))
                  0: begin
                     fresh = 1'b0;
                     mode  = sdcg_pkg::mode_type'($urandom_range(0, 7));
                  end
                  1:       mode = sdcg_pkg::MODE_UNKNOWN;
                  default: mode = sdcg_pkg::MODE_NONE;
               endcase
            end
            RUN_BLOCKED: begin
               case ($urandom_range(0, 2))
                  0: begin
                     mode    = sdcg_pkg::MODE_CONFLICT;
                     allowed = 1'($urandom_range(0, 1));
                  end
                  1: begin
                     mode    = sdcg_pkg::MODE_TRANSFER;
                     allowed = 1'($urandom_range(0, 1));
                  end
                  default: allowed = 1'b0;
               endcase
            end
            default: begin
               fresh   = 1'($urandom_range(0, 1));
               allowed = 1'($urandom_range(0, 1));
               mode    = sdcg_pkg::mode_type'($urandom_range(0, 7));
            end
         endcase
         send_beat(fresh, allowed, mode, sim_ms);
      end
   endtask

   // Result side: random stalls, plus one long hold-off that backs the gate up.
   initial begin : sink
      int hold_count;
      forever begin
         @(posedge clock);
         if (long_hold_due && !long_hold_done) begin
            rsp_ready <= 1'b0;
            hold_count = 0;
            while (hold_count < LONG_HOLD_CYCLES) begin
               @(posedge clock);
               hold_count++;
            end
            long_hold_done = 1'b1;
            rsp_ready <= 1'b1;
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Abort a hung run.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      sdcg_pkg::field_type dwell;
      sdcg_pkg::field_type trip;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // out of reset the gate is unconfigured
      send_beat(1'b1, 1'b1, sdcg_pkg::MODE_GRID, 32'h0000_0000);
      send_beat(1'b0, 1'b0, sdcg_pkg::MODE_NONE, 32'hFFFF_FFFF);

      // immediate dwell and trip: every class of sample
      apply_config(1'b1, '0, '0);
      send_beat(1'b1, 1'b1, sdcg_pkg::MODE_GRID, 32'd5);
      send_beat(1'b0, 1'b1, sdcg_pkg::MODE_GRID, 32'd6);
      send_beat(1'b1, 1'b1, sdcg_pkg::MODE_CONFLICT, 32'd7);
      send_beat(1'b1, 1'b1, sdcg_pkg::MODE_TRANSFER, 32'd8);
      send_beat(1'b1, 1'b0, sdcg_pkg::MODE_SYNC, 32'd9);
      send_beat(1'b0, 1'b1, sdcg_pkg::MODE_CONFLICT, 32'd10);
      send_beat(1'b1, 1'b1, sdcg_pkg::MODE_UNKNOWN, 32'd11);
      send_beat(1'b1, 1'b1, sdcg_pkg::MODE_NONE, 32'd12);
      send_beat(1'b1, 1'b1, sdcg_pkg::MODE_ISLAND, 32'd13);

      // dwell across the time wrap, mode change restart, loss trip boundary
      apply_config(1'b1, 32'd100, 32'd50);
      send_beat(1'b1, 1'b1, sdcg_pkg::MODE_GRID, 32'hFFFF_FFC0);
      send_beat(1'b1, 1'b1, sdcg_pkg::MODE_GRID, 32'h0000_0010);
      send_beat(1'b1, 1'b1, sdcg_pkg::MODE_GRID, 32'h0000_0024);
      send_beat(1'b1, 1'b1, sdcg_pkg::MODE_GEN, 32'h0000_0030);
      send_beat(1'b1, 1'b1, sdcg_pkg::MODE_GEN, 32'h0000_0094);
      send_beat(1'b1, 1'b0, sdcg_pkg::MODE_NONE, 32'h0000_0100);
      send_beat(1'b1, 1'b0, sdcg_pkg::MODE_NONE, 32'h0000_0131);
      send_beat(1'b1, 1'b0, sdcg_pkg::MODE_NONE, 32'h0000_0132);
      send_beat(1'b0, 1'b1, sdcg_pkg::MODE_ISLAND, 32'h0000_0140);

      // largest dwell and trip, reached only by a full wrap
      apply_config(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(1'b1, 1'b1, sdcg_pkg::MODE_GRID, 32'h0000_0000);
      send_beat(1'b1, 1'b1, sdcg_pkg::MODE_GRID, 32'hFFFF_FFFE);
      send_beat(1'b1, 1'b1, sdcg_pkg::MODE_GRID, 32'hFFFF_FFFF);
      send_beat(1'b0, 1'b0, sdcg_pkg::MODE_TRANSFER, 32'h0000_0007);
      send_beat(1'b0, 1'b0, sdcg_pkg::MODE_TRANSFER, 32'h0000_0006);

      // random phases, each with its own setting
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p % 6)
            0: begin
               dwell = $urandom_range(1, 400);
               trip  = $urandom_range(1, 400);
            end
            1: begin
               dwell = '0;
               trip  = $urandom_range(1, 300);
            end
            2: begin
               dwell = $urandom_range(1, 300);
               trip  = '0;
            end
            3: begin
               dwell = 32'hFFFF_FFFF;
               trip  = 32'hFFFF_FFFF;
            end
            4: begin
               dwell = $urandom;
               trip  = $urandom;
            end
            default: begin
               dwell = $urandom_range(1, 60);
               trip  = $urandom_range(1, 60);
            end
         endcase
         apply_config(p != 4, dwell, trip);
         ms_step = $urandom_range(1, 120);
         sim_ms  = (p == 3) ? 32'hFFFF_FF00 : $urandom;
         gaps_on = (p < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
         if (p == 2) begin
            long_hold_due = 1'b1;
         end
         random_phase(PHASE_BEATS);
      end

      wait_drained();
      if (mismatches == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
